/* rtl/core/bmcd_pkg.sv */
// ----------------------------------------------------------------------------
// bmcd_pkg
// Shared types, constants and helpers of the block mode color downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bmcd_pkg;

  localparam int MAX_SIDE      = 8;
  localparam int TABLE_ENTRIES = 64;

  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 3 * CHAN_W;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int SIZE_W    = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int COUNT_W   = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 1'd1;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic [SIZE_W-1:0]  size_t;

  // One pixel request travelling down the cell chain.
  typedef struct packed {
    logic   valid;
    logic   last;   // closes its block
    logic   done;   // some cell has already counted it
    color_t color;
    count_t count;  // count of its color once done
  } token_t;

  // Zero acts as one, anything above MAX_SIDE saturates.
  function automatic side_t side_of(logic [CFG_W-1:0] value);
    side_t side;
    if (value == '0) begin
      side = side_t'(1);
    end else if (int'(value) > MAX_SIDE) begin
      side = side_t'(MAX_SIDE);
    end else begin
      side = side_t'(value);
    end
    return side;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bmcd_if.sv */
// ----------------------------------------------------------------------------
// bmcd_if
// Valid/ready channels of the block mode color downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmcd_cfg_if
  import bmcd_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface bmcd_pixel_if
  import bmcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel0;
  logic [CHAN_W-1:0] channel1;
  logic [CHAN_W-1:0] channel2;

  modport source (output valid, channel0, channel1, channel2, input ready);
  modport sink   (input valid, channel0, channel1, channel2, output ready);
endinterface

interface bmcd_mode_if
  import bmcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] mode_channel0;
  logic [CHAN_W-1:0] mode_channel1;
  logic [CHAN_W-1:0] mode_channel2;

  modport source (output valid, mode_channel0, mode_channel1, mode_channel2, input ready);
  modport sink   (input valid, mode_channel0, mode_channel1, mode_channel2, output ready);
endinterface

`default_nettype wire

/* rtl/core/bmcd_cell.sv */
// ----------------------------------------------------------------------------
// bmcd_cell
// One table entry of the color histogram and one stage of the pixel chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bmcd_cell
  import bmcd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  logic   used;
  color_t color;
  count_t count;
  logic   hit;
  logic   claim;
  token_t tok_next;

  assign hit   = tok_in.valid && !tok_in.done && used && (color == tok_in.color);
  assign claim = tok_in.valid && !tok_in.done && !used;

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.done  = 1'b1;
      tok_next.count = count + count_t'(1);
    end else if (claim) begin
      tok_next.done  = 1'b1;
      tok_next.count = count_t'(1);
    end
  end

  // Drop the entry once the closing pixel of the block has passed.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (adv && tok_in.valid) begin
      used <= tok_in.last ? 1'b0 : (used | claim);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (claim) begin
        color <= tok_in.color;
        count <= count_t'(1);
      end else if (hit) begin
        count <= count + count_t'(1);
      end
    end
  end

  // Hand the request to the next cell; hold it while the chain is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bmcd_mode_track.sv */
// ----------------------------------------------------------------------------
// bmcd_mode_track
// Tracks the most frequent color of the block and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmcd_mode_track
  import bmcd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    adv,
  input  wire token_t  tok,
  bmcd_mode_if.source  mode
);

  color_t top_color;
  count_t top_count;
  logic   take;
  logic   better;
  color_t color_next;

  assign take       = adv && tok.valid;
  assign better     = tok.done && (tok.count > top_count);
  assign color_next = better ? tok.color : top_color;

  // Strictly greater only: on a tie the earlier color holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_color <= '0;
      top_count <= '0;
    end else if (take) begin
      if (tok.last) begin
        top_color <= '0;
        top_count <= '0;
      end else if (better) begin
        top_color <= tok.color;
        top_count <= tok.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode.valid <= 1'b0;
    end else if (take && tok.last) begin
      mode.valid <= 1'b1;
    end else if (mode.ready) begin
      mode.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok.last) begin
      mode.mode_channel0 <= color_next[3*CHAN_W-1:2*CHAN_W];
      mode.mode_channel1 <= color_next[2*CHAN_W-1:CHAN_W];
      mode.mode_channel2 <= color_next[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/block_mode_color_downsample.sv */
// ----------------------------------------------------------------------------
// block_mode_color_downsample
// Emits the most frequent color of each block of pixels.
// ----------------------------------------------------------------------------
// Pixels of one block arrive in row order on the pixel channel; after the
// block's last pixel (width times height pixels, each side register taken
// as 1 when zero and capped at MAX_SIDE) one request with the block's most
// frequent color leaves on the mode channel. On a tie the color that first
// reached the top count wins. The histogram lives in a chain of
// TABLE_ENTRIES cells, one distinct color per cell; each pixel walks the
// chain one cell per cycle and is counted by the cell that holds its color
// or claimed by the first free cell. A pixel whose color finds no free cell
// is not counted. Throughput is one pixel per cycle while the chain is not
// halted; a block's result passes through the TABLE_ENTRIES cell registers
// (the first cell takes the last pixel at the edge that accepts it) and
// then the result register. The whole chain halts while a finished result
// waits on the mode channel. Size registers take effect on the next pixel
// accepted; writes are taken in every cycle out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

module block_mode_color_downsample
  import bmcd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  bmcd_cfg_if.sink    cfg,
  bmcd_pixel_if.sink  pixel,
  bmcd_mode_if.source mode
);

  // Size registers, raw as written.
  logic [CFG_W-1:0] block_width;
  logic [CFG_W-1:0] block_height;

  size_t  block_size;
  size_t  pixels_seen;
  logic [SIZE_W:0] seen_inc;
  logic   adv;
  logic   accept;
  logic   last_pixel;

  // One token slot in front of each cell, plus the tail of the chain.
  token_t tok [TABLE_ENTRIES+1];

  // Configuration: ready out of reset, indexes outside the list are ignored.
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_width  <= CFG_W'(1);
      block_height <= CFG_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BLOCK_WIDTH:  block_width  <= cfg.data;
        REG_BLOCK_HEIGHT: block_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign block_size = size_t'(side_of(block_width)) * size_t'(side_of(block_height));

  // Advance the chain unless a result sits untaken in the output register.
  assign adv         = !(mode.valid && !mode.ready);
  assign pixel.ready = adv && !rst;
  assign accept      = pixel.valid && pixel.ready;

  // Close the block on the first pixel that reaches or passes its size.
  assign seen_inc   = {1'b0, pixels_seen} + (SIZE_W+1)'(1);
  assign last_pixel = seen_inc >= {1'b0, block_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_seen <= '0;
    end else if (accept) begin
      pixels_seen <= last_pixel ? '0 : seen_inc[SIZE_W-1:0];
    end
  end

  // Build the request that enters the first cell.
  always_comb begin
    tok[0].valid = accept;
    tok[0].last  = last_pixel;
    tok[0].done  = 1'b0;
    tok[0].color = {pixel.channel0, pixel.channel1, pixel.channel2};
    tok[0].count = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    bmcd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Fold the tail of the chain into the running best and emit on block end.
  bmcd_mode_track u_track (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .tok  (tok[TABLE_ENTRIES]),
    .mode (mode)
  );

  // A closing request leaving the chain always loads the result register.
  a_tail_emits: assert property (@(posedge clk) disable iff (rst)
    adv && tok[TABLE_ENTRIES].valid && tok[TABLE_ENTRIES].last |=> mode.valid)
    else $error("closing request left the chain without a result");

  // A stalled chain keeps its tail request.
  a_tail_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(tok[TABLE_ENTRIES]))
    else $error("chain tail moved during a stall");

  // The pixel that closes a block restarts the pixel count.
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    accept && last_pixel |=> pixels_seen == '0)
    else $error("pixel count not restarted at block end");

endmodule

`default_nettype wire
